// ----- hw/rtl/lru_kvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, command codes and the lookup summary shared by the cache modules.
// ----------------------------------------------------------------------------
package lru_kvc_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int FIELD_W     = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int AGE_W       = $clog2(DEPTH);
	localparam int USED_W      = $clog2(DEPTH + 1);
	localparam int CAP_W       = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef logic [KEY_WIDTH-1:0]   key_t;
	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [AGE_W-1:0]       age_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		idx_t free_idx;
		idx_t victim_idx;
	} lookup_t;

endpackage

// ----- hw/rtl/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//   Channel   Handshake            Payload
//   command   start / busy         cmd, key, value
//   result    done (strobe)        hit, read_value
//   config    cfg_we               cfg_data (capacity)
//
// One item is accepted every cycle; busy stays low.
// A get is registered as valid_s1, then done is registered together with hit and
// read_value; a put raises no done.
// Each item is registered, then compared against all entries and the table
// updated in the same cycle, so the next item sees the updated table.
// Reset clears the table at once; no clearing pass follows.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             cmd,
	input  logic [lru_kvc_pkg::FIELD_W-1:0]  key,
	input  logic [lru_kvc_pkg::FIELD_W-1:0]  value,
	output logic                             done,
	output logic                             hit,
	output logic [lru_kvc_pkg::FIELD_W-1:0]  read_value,
	input  logic                             cfg_we,
	input  logic [lru_kvc_pkg::CAP_W-1:0]    cfg_data
);

	logic                                       valid_s1;
	logic                                       cmd_s1;
	lru_kvc_pkg::key_t                          key_s1;
	lru_kvc_pkg::val_t                          value_s1;
	logic [lru_kvc_pkg::USED_W-1:0]             cap_q;
	logic                                       done_q;
	logic                                       hit_q;
	logic [lru_kvc_pkg::FIELD_W-1:0]            read_value_q;

	lru_kvc_pkg::lookup_t                       lookup;
	logic [lru_kvc_pkg::DEPTH-1:0]              entry_valid;
	lru_kvc_pkg::key_t [lru_kvc_pkg::DEPTH-1:0] entry_key;
	lru_kvc_pkg::age_t [lru_kvc_pkg::DEPTH-1:0] entry_age;
	logic [lru_kvc_pkg::USED_W-1:0]             entries_used;
	lru_kvc_pkg::val_t                          hit_value;
	logic [lru_kvc_pkg::USED_W-1:0]             cap_next;

	assign busy = 1'b0;

	// Capacity zero behaves as one and values above the depth saturate.
	always_comb begin
		priority if (cfg_data == '0) begin
			cap_next = lru_kvc_pkg::USED_W'(1);
		end else if (int'(cfg_data) > lru_kvc_pkg::DEPTH) begin
			cap_next = lru_kvc_pkg::USED_W'(lru_kvc_pkg::DEPTH);
		end else begin
			cap_next = lru_kvc_pkg::USED_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= lru_kvc_pkg::USED_W'(
			            (int'(lru_kvc_pkg::CAP_RESET) > lru_kvc_pkg::DEPTH) ?
			            lru_kvc_pkg::DEPTH : int'(lru_kvc_pkg::CAP_RESET));
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cap_next;
			end
			valid_s1 <= start && !busy;
			done_q   <= valid_s1 && cmd_s1 == lru_kvc_pkg::CMD_GET;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= cmd;
			key_s1   <= key[lru_kvc_pkg::KEY_WIDTH-1:0];
			value_s1 <= value[lru_kvc_pkg::VALUE_WIDTH-1:0];
		end
		if (valid_s1) begin
			hit_q        <= lookup.hit;
			read_value_q <= lookup.hit ? lru_kvc_pkg::FIELD_W'(hit_value) :
			                lru_kvc_pkg::FIELD_W'(lru_kvc_pkg::val_t'('1));
		end
	end

	lru_kvc_lookup u_lookup (
		.key          (key_s1),
		.entry_valid  (entry_valid),
		.entry_key    (entry_key),
		.entry_age    (entry_age),
		.entries_used (entries_used),
		.lookup       (lookup)
	);

	lru_kvc_table u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.cmd_s1       (cmd_s1),
		.key_s1       (key_s1),
		.value_s1     (value_s1),
		.cap_eff      (cap_q),
		.lookup       (lookup),
		.entry_valid  (entry_valid),
		.entry_key    (entry_key),
		.entry_age    (entry_age),
		.entries_used (entries_used),
		.hit_value    (hit_value)
	);

	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

// ----- hw/rtl/lru_kvc_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache lookup
// Parallel key compare, lowest free entry and least recent entry search.
// ----------------------------------------------------------------------------
module lru_kvc_lookup (
	input  lru_kvc_pkg::key_t                         key,
	input  logic [lru_kvc_pkg::DEPTH-1:0]             entry_valid,
	input  lru_kvc_pkg::key_t [lru_kvc_pkg::DEPTH-1:0] entry_key,
	input  lru_kvc_pkg::age_t [lru_kvc_pkg::DEPTH-1:0] entry_age,
	input  logic [lru_kvc_pkg::USED_W-1:0]            entries_used,
	output lru_kvc_pkg::lookup_t                      lookup
);

	lru_kvc_pkg::age_t oldest_age;

	// Valid entries hold distinct ages 0 to entries_used-1, so the least
	// recent entry is the one whose age equals entries_used-1.
	assign oldest_age = lru_kvc_pkg::AGE_W'(entries_used - 1'b1);

	always_comb begin
		lookup = '0;
		for (int i = lru_kvc_pkg::DEPTH - 1; i >= 0; i--) begin
			if (entry_valid[i] && entry_key[i] == key) begin
				lookup.hit     = 1'b1;
				lookup.hit_idx = lru_kvc_pkg::IDX_W'(i);
			end
			if (!entry_valid[i]) begin
				lookup.free_idx = lru_kvc_pkg::IDX_W'(i);
			end
			if (entry_valid[i] && entry_age[i] == oldest_age) begin
				lookup.victim_idx = lru_kvc_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// ----- hw/rtl/lru_kvc_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache table
// Entry storage with age update on hit, fill and eviction.
// ----------------------------------------------------------------------------
module lru_kvc_table (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       valid_s1,
	input  logic                                       cmd_s1,
	input  lru_kvc_pkg::key_t                          key_s1,
	input  lru_kvc_pkg::val_t                          value_s1,
	input  logic [lru_kvc_pkg::USED_W-1:0]             cap_eff,
	input  lru_kvc_pkg::lookup_t                       lookup,
	output logic [lru_kvc_pkg::DEPTH-1:0]              entry_valid,
	output lru_kvc_pkg::key_t [lru_kvc_pkg::DEPTH-1:0] entry_key,
	output lru_kvc_pkg::age_t [lru_kvc_pkg::DEPTH-1:0] entry_age,
	output logic [lru_kvc_pkg::USED_W-1:0]             entries_used,
	output lru_kvc_pkg::val_t                          hit_value
);

	logic [lru_kvc_pkg::DEPTH-1:0]              valid_q;
	lru_kvc_pkg::key_t [lru_kvc_pkg::DEPTH-1:0] key_q;
	lru_kvc_pkg::val_t [lru_kvc_pkg::DEPTH-1:0] value_q;
	lru_kvc_pkg::age_t [lru_kvc_pkg::DEPTH-1:0] age_q;
	logic [lru_kvc_pkg::USED_W-1:0]             used_q;

	logic              is_put;
	logic              do_fill;
	logic              do_touch;
	lru_kvc_pkg::idx_t tgt;
	lru_kvc_pkg::age_t ref_age;

	assign is_put   = valid_s1 && cmd_s1 == lru_kvc_pkg::CMD_PUT;
	assign do_fill  = is_put && !lookup.hit && used_q < cap_eff;
	assign do_touch = valid_s1 && (lookup.hit || (is_put && !do_fill));
	assign tgt      = lookup.hit ? lookup.hit_idx :
	                  (do_fill ? lookup.free_idx : lookup.victim_idx);
	assign ref_age  = age_q[tgt];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '0;
			used_q  <= '0;
		end else begin
			for (int i = 0; i < lru_kvc_pkg::DEPTH; i++) begin
				if ((do_fill || do_touch) && lru_kvc_pkg::IDX_W'(i) == tgt) begin
					age_q[i] <= '0;
				end else if (do_fill && valid_q[i]) begin
					age_q[i] <= age_q[i] + 1'b1;
				end else if (do_touch && valid_q[i] && age_q[i] < ref_age) begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
			if (do_fill) begin
				valid_q[tgt] <= 1'b1;
				used_q       <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_put) begin
			value_q[tgt] <= value_s1;
			if (!lookup.hit) begin
				key_q[tgt] <= key_s1;
			end
		end
	end

	assign entry_valid  = valid_q;
	assign entry_key    = key_q;
	assign entry_age    = age_q;
	assign entries_used = used_q;
	assign hit_value    = value_q[lookup.hit_idx];

endmodule
